// File: sv/bfp_pkg.sv
// ----------------------------------------------------------------------------
// bfp_pkg
// shared types, register codes and result helpers for the byte frame parser
// ----------------------------------------------------------------------------
package bfp_pkg;

  localparam int MAX_FRAME_DEF        = 1024;
  localparam int HEADER_BYTES_DEF     = 5;
  localparam int LEN_FIELD_OFFSET_DEF = 3;
  localparam int CMD_OFFSET_DEF       = 2;

  // width for length compares: 16-bit length field plus header and checksum bytes
  localparam int CMP_W = 18;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_HEAD_BYTE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TAIL_BYTE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LEN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RSV_TYPE  = 3'd4;

  localparam logic [7:0]  HEAD_BYTE_RST = 8'd126;
  localparam logic [7:0]  TAIL_BYTE_RST = 8'd127;
  localparam logic [10:0] MIN_LEN_RST   = 11'd6;
  localparam logic [10:0] MAX_LEN_RST   = 11'd1024;
  localparam logic [7:0]  RSV_TYPE_RST  = 8'd0;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_SHORT = 2'd1;
  localparam logic [1:0] ST_OVER  = 2'd2;
  localparam logic [1:0] ST_CSUM  = 2'd3;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_END  = 1'b1;

  localparam int RQ_DEPTH = 4;
  localparam int RQ_PTR_W = 2;
  localparam int RQ_CNT_W = 3;

  typedef struct packed {
    logic [7:0]  head_byte;
    logic [7:0]  tail_byte;
    logic [10:0] min_len;
    logic [10:0] max_len;
    logic [7:0]  rsv_type;
  } cfg_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  byte_value;
    logic [9:0]  byte_index;
    logic [1:0]  status;
    logic [7:0]  command;
    logic [7:0]  frame_type;
    logic [7:0]  data_number;
    logic [10:0] payload_len;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [1:0] num;
    res_t       r0;
    res_t       r1;
  } push_t;

  function automatic res_t byte_res(logic [9:0] idx, logic [7:0] b);
    res_t r;
    r            = '0;
    r.kind       = KIND_BYTE;
    r.byte_value = b;
    r.byte_index = idx;
    return r;
  endfunction

  function automatic res_t end_res(logic [1:0] st, logic [7:0] cmd, logic [7:0] typ,
                                   logic [7:0] num, logic [10:0] plen);
    res_t r;
    r             = '0;
    r.kind        = KIND_END;
    r.status      = st;
    r.command     = cmd;
    r.frame_type  = typ;
    r.data_number = num;
    r.payload_len = plen;
    return r;
  endfunction

endpackage

// File: sv/bfp_deframer.sv
// ----------------------------------------------------------------------------
// bfp_deframer
// frame state machine: head/tail detection, body collection and frame close
// ----------------------------------------------------------------------------
module bfp_deframer #(
  parameter int MAX_FRAME        = bfp_pkg::MAX_FRAME_DEF,
  parameter int HEADER_BYTES     = bfp_pkg::HEADER_BYTES_DEF,
  parameter int LEN_FIELD_OFFSET = bfp_pkg::LEN_FIELD_OFFSET_DEF,
  parameter int CMD_OFFSET       = bfp_pkg::CMD_OFFSET_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_fire,
  input  logic [7:0]     in_byte,
  input  bfp_pkg::cfg_t  cfg,
  output bfp_pkg::push_t push
);
  import bfp_pkg::*;

  localparam int CNT_W = $clog2(MAX_FRAME + 1);

  typedef enum logic [1:0] {PH_IDLE, PH_HEAD, PH_DATA, PH_TAIL} phase_t;

  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic [7:0]       sum;
    logic [7:0]       prev;
    logic [7:0]       cmd;
    logic [15:0]      hlen;
    logic [7:0]       ptype;
    logic [7:0]       pnum;
  } frm_t;

  phase_t           phase_r, phase_nxt;
  frm_t             frm_r, frm_nxt;
  frm_t             s1, s2;
  logic [CMP_W-1:0] bound;
  logic             len_match;
  logic [7:0]       csum;

  function automatic frm_t store_f(frm_t s, logic [7:0] b);
    frm_t             r;
    logic [CMP_W-1:0] ix;
    r  = s;
    ix = CMP_W'(s.cnt);
    if (ix == CMP_W'(CMD_OFFSET)) r.cmd = b;
    if (ix == CMP_W'(LEN_FIELD_OFFSET)) r.hlen[7:0] = b;
    if (ix == CMP_W'(LEN_FIELD_OFFSET + 1)) r.hlen[15:8] = b;
    if (ix == CMP_W'(HEADER_BYTES)) r.ptype = b;
    if (ix == CMP_W'(HEADER_BYTES + 1)) r.pnum = b;
    r.sum  = s.sum + b;
    r.prev = b;
    r.cnt  = s.cnt + CNT_W'(1);
    return r;
  endfunction

  function automatic logic ovf_f(logic [CNT_W-1:0] c, logic [CMP_W-1:0] lim);
    return CMP_W'(c) >= lim;
  endfunction

  assign bound = (CMP_W'(cfg.max_len) < CMP_W'(MAX_FRAME)) ? CMP_W'(cfg.max_len)
                                                           : CMP_W'(MAX_FRAME);
  assign s1        = store_f(frm_r, cfg.tail_byte);
  assign s2        = store_f(s1, in_byte);
  assign len_match = (CMP_W'(frm_r.hlen) + CMP_W'(HEADER_BYTES + 1)) == CMP_W'(frm_r.cnt);
  assign csum      = frm_r.sum - frm_r.prev;

  always_comb begin
    phase_nxt = phase_r;
    frm_nxt   = frm_r;
    push      = '0;
    if (in_fire) begin
      case (phase_r)
        PH_IDLE: begin
          if (in_byte == cfg.head_byte) begin
            phase_nxt = PH_HEAD;
            frm_nxt   = '0;
          end
        end
        PH_HEAD: begin
          phase_nxt = (in_byte == cfg.head_byte) ? PH_DATA : PH_IDLE;
        end
        PH_DATA: begin
          if (in_byte == cfg.tail_byte) begin
            phase_nxt = PH_TAIL;
          end else if (ovf_f(frm_r.cnt, bound)) begin
            push.num  = 2'd1;
            push.r0   = end_res(ST_OVER, 8'd0, 8'd0, 8'd0, 11'd0);
            phase_nxt = PH_IDLE;
          end else begin
            push.num = 2'd1;
            push.r0  = byte_res(10'(frm_r.cnt), in_byte);
            frm_nxt  = store_f(frm_r, in_byte);
          end
        end
        PH_TAIL: begin
          phase_nxt = PH_IDLE;
          if (in_byte == cfg.tail_byte && CMP_W'(frm_r.cnt) < CMP_W'(cfg.min_len)) begin
            push.num = 2'd1;
            push.r0  = end_res(ST_SHORT, 8'd0, 8'd0, 8'd0, 11'd0);
          end else if (in_byte == cfg.tail_byte && len_match) begin
            push.num = 2'd1;
            if (csum != frm_r.prev) begin
              push.r0 = end_res(ST_CSUM, 8'd0, 8'd0, 8'd0, 11'd0);
            end else if (|frm_r.hlen[15:1]) begin
              push.r0 = end_res(ST_OK, frm_r.cmd, frm_r.ptype, frm_r.pnum, frm_r.hlen[10:0]);
            end else begin
              push.r0 = end_res(ST_OK, frm_r.cmd, cfg.rsv_type, 8'd0, frm_r.hlen[10:0]);
            end
          end else if (ovf_f(frm_r.cnt, bound)) begin
            push.num = 2'd1;
            push.r0  = end_res(ST_OVER, 8'd0, 8'd0, 8'd0, 11'd0);
          end else begin
            push.num = 2'd2;
            push.r0  = byte_res(10'(frm_r.cnt), cfg.tail_byte);
            frm_nxt  = s1;
            if (ovf_f(s1.cnt, bound)) begin
              push.r1 = end_res(ST_OVER, 8'd0, 8'd0, 8'd0, 11'd0);
            end else begin
              push.r1   = byte_res(10'(s1.cnt), in_byte);
              frm_nxt   = s2;
              phase_nxt = PH_DATA;
            end
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
    if (push.num == 2'd1) push.r0.last = 1'b1;
    if (push.num == 2'd2) push.r1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      frm_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      frm_r   <= frm_nxt;
    end
  end

  a_push_needs_fire: assert property (@(posedge clk) disable iff (!rst_n)
    push.num != 2'd0 |-> in_fire)
    else $error("results pushed without an input transaction");

  a_last_marking: assert property (@(posedge clk) disable iff (!rst_n)
    (push.num != 2'd1 || push.r0.last) &&
    (push.num != 2'd2 || (push.r1.last && !push.r0.last)))
    else $error("last flag not on the final result of a transaction");

  a_end_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (push.num != 2'd0 && push.r0.kind == KIND_END) |->
      (push.r0.byte_value == 8'd0 && push.r0.byte_index == 10'd0 && push.num == 2'd1))
    else $error("end of frame result carries body byte fields or follows");

endmodule

// File: sv/bfp_res_queue.sv
// ----------------------------------------------------------------------------
// bfp_res_queue
// small shifting result queue: takes up to two results per cycle and, while out_ready is high, gives one
// ----------------------------------------------------------------------------
module bfp_res_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  bfp_pkg::push_t push,
  output logic           space,
  output logic           out_valid,
  input  logic           out_ready,
  output bfp_pkg::res_t  out_res
);
  import bfp_pkg::*;

  res_t                q_r [RQ_DEPTH];
  res_t                q_tmp [RQ_DEPTH];
  logic [RQ_CNT_W-1:0] cnt_r, cnt_nxt, cnt_tmp;
  logic [RQ_PTR_W-1:0] wp0, wp1;
  logic                pop;

  assign out_valid = cnt_r != '0;
  assign pop       = out_valid && out_ready;
  assign space     = cnt_r <= RQ_CNT_W'(RQ_DEPTH - 2);
  assign out_res   = q_r[0];
  assign wp0       = cnt_tmp[RQ_PTR_W-1:0];
  assign wp1       = wp0 + RQ_PTR_W'(1);

  always_comb begin
    q_tmp   = q_r;
    cnt_tmp = cnt_r;
    if (pop) begin
      for (int i = 0; i < RQ_DEPTH - 1; i++) begin
        q_tmp[i] = q_r[i+1];
      end
      cnt_tmp = cnt_r - RQ_CNT_W'(1);
    end
    if (push.num != 2'd0) q_tmp[wp0] = push.r0;
    if (push.num == 2'd2) q_tmp[wp1] = push.r1;
    cnt_nxt = cnt_tmp + RQ_CNT_W'(push.num);
  end

  always_ff @(posedge clk) begin
    q_r <= q_tmp;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= RQ_CNT_W'(RQ_DEPTH))
    else $error("result queue overfilled");

endmodule

// File: sv/byte_frame_parser_checksum_core.sv
// ----------------------------------------------------------------------------
// byte_frame_parser_checksum_core
// byte stream deframer with 8-bit additive checksum check
// ----------------------------------------------------------------------------
// in_*  : one received byte per transaction (valid/ready)
// out_* : result transactions; kind 0 is a tentative body byte with its index,
//         kind 1 ends a frame with a status and, on ok, the header fields
//         out_last marks the final result caused by one input byte
// cfg_* : register writes (head, tail, min length, max length, reserved type),
//         taken in the same cycle; the user must write them only while no
//         frame work is pending; the block itself does not enforce it
// throughput: one byte per cycle while in_ready is high; a byte gives zero,
//   one or two results into a registered four-entry queue whose head drives
//   out_*, drained one result per cycle while out_ready is high, so bytes
//   giving two results (tail byte stored as data) slow intake to that rate
// in_ready is high while the queue has room for two results; a stalled
//   receiver fills the queue and then holds off the input
// reset: frame state idle, queue empty, registers at their default values
// ----------------------------------------------------------------------------
module byte_frame_parser_checksum_core #(
  parameter int MAX_FRAME        = bfp_pkg::MAX_FRAME_DEF,
  parameter int HEADER_BYTES     = bfp_pkg::HEADER_BYTES_DEF,
  parameter int LEN_FIELD_OFFSET = bfp_pkg::LEN_FIELD_OFFSET_DEF,
  parameter int CMD_OFFSET       = bfp_pkg::CMD_OFFSET_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     in_byte,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_kind,
  output logic [7:0]                     out_byte_value,
  output logic [9:0]                     out_byte_index,
  output logic [1:0]                     out_status,
  output logic [7:0]                     out_command,
  output logic [7:0]                     out_frame_type,
  output logic [7:0]                     out_data_number,
  output logic [10:0]                    out_payload_len,
  output logic                           out_last,
  input  logic                           cfg_we,
  input  logic [bfp_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [bfp_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import bfp_pkg::*;

  cfg_t  cfg_r, cfg_nxt;
  push_t push;
  res_t  out_res;
  logic  space;
  logic  in_fire;

  assign in_ready = space;
  assign in_fire  = in_valid && space;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx)
        CFG_HEAD_BYTE: cfg_nxt.head_byte = cfg_wdata[7:0];
        CFG_TAIL_BYTE: cfg_nxt.tail_byte = cfg_wdata[7:0];
        CFG_MIN_LEN:   cfg_nxt.min_len   = cfg_wdata;
        CFG_MAX_LEN:   cfg_nxt.max_len   = cfg_wdata;
        CFG_RSV_TYPE:  cfg_nxt.rsv_type  = cfg_wdata[7:0];
        default:       cfg_nxt           = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.head_byte <= HEAD_BYTE_RST;
      cfg_r.tail_byte <= TAIL_BYTE_RST;
      cfg_r.min_len   <= MIN_LEN_RST;
      cfg_r.max_len   <= MAX_LEN_RST;
      cfg_r.rsv_type  <= RSV_TYPE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  bfp_deframer #(
    .MAX_FRAME       (MAX_FRAME),
    .HEADER_BYTES    (HEADER_BYTES),
    .LEN_FIELD_OFFSET(LEN_FIELD_OFFSET),
    .CMD_OFFSET      (CMD_OFFSET)
  ) u_deframer (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_fire(in_fire),
    .in_byte(in_byte),
    .cfg    (cfg_r),
    .push   (push)
  );

  bfp_res_queue u_res_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .space    (space),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_res  (out_res)
  );

  assign out_kind        = out_res.kind;
  assign out_byte_value  = out_res.byte_value;
  assign out_byte_index  = out_res.byte_index;
  assign out_status      = out_res.status;
  assign out_command     = out_res.command;
  assign out_frame_type  = out_res.frame_type;
  assign out_data_number = out_res.data_number;
  assign out_payload_len = out_res.payload_len;
  assign out_last        = out_res.last;

endmodule
